### hdl/ptwcnx_pkg.sv
// Shared types and constants for the page-table walk and NX-clear block.
`timescale 1ns / 1ps
package ptwcnx_pkg;

   localparam int unsigned MEM_WORDS_DEF = 65536;

   // Width of a walk's word index: table base bits 51:3 plus a 9-bit index, with carry.
   localparam int WIDX_W = 50;

   localparam int PSE_BIT = 7;
   localparam int NX_BIT  = 63;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WALK  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_TOP_ZERO = 3'd1,
      ST_L3_ZERO  = 3'd2,
      ST_L2_ZERO  = 3'd3,
      ST_OUTSIDE  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_WALK
   } state_type;

endpackage

### hdl/ptwcnx_mem.sv
// Single-port synchronous memory holding the 64-bit physical memory image.
`timescale 1ns / 1ps
module ptwcnx_mem #(
   parameter int unsigned DEPTH = ptwcnx_pkg::MEM_WORDS_DEF,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic          wr_en,
   input  logic [AW-1:0] addr,
   input  logic [63:0]   wdata,
   output logic [63:0]   rdata
);

   logic [63:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata <= mem[addr];
      end
   end

endmodule

### hdl/page_table_walk_clear_nx_core.sv
// A walk is up to four dependent reads of the single-port image memory; the cycle in which
// the fourth read's data arrives also writes the NX-cleared entry back. A walk keeps the
// core busy until its result, so no new item is taken before the walk is through.
// Reads also hold busy until their data returns; writes and rejected items are taken one every cycle.
// The result strobe lasts one cycle and cannot be stalled; busy drops as it is shown.
// Synchronous reset clears the control state only; the memory image is undefined until written.
`timescale 1ns / 1ps
module page_table_walk_clear_nx_core #(
   parameter int unsigned MEM_WORDS = ptwcnx_pkg::MEM_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_word_index,
   input  logic [63:0] req_write_data,
   input  logic [51:0] req_table_base,
   input  logic [47:0] req_virt_addr,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_read_data,
   output logic [15:0] rsp_entry_index,
   output logic [63:0] rsp_entry_before,
   output logic [63:0] rsp_entry_after
);

   localparam int unsigned AW = $clog2(MEM_WORDS);
   localparam int WIDX_W = ptwcnx_pkg::WIDX_W;
   localparam logic [WIDX_W-1:0] MEM_LIMIT = WIDX_W'(MEM_WORDS);

   ptwcnx_pkg::state_type state_ff, state_in;
   logic [1:0]    level_ff, level_in;
   logic [26:0]   va_ff, va_in;
   logic [AW-1:0] addr_ff, addr_in;

   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]  status_ff, status_in;
   logic [63:0] read_data_ff, read_data_in;
   logic [15:0] entry_index_ff, entry_index_in;
   logic [63:0] before_ff, before_in;
   logic [63:0] after_ff, after_in;

   logic          mem_rd_en, mem_wr_en;
   logic [AW-1:0] mem_addr;
   logic [63:0]   mem_wdata, mem_rdata;

   logic              accept;
   logic [WIDX_W-1:0] req_idx, top_idx, next_idx;
   logic              pse;

   ptwcnx_mem #(
      .DEPTH (MEM_WORDS),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .rd_en (mem_rd_en),
      .wr_en (mem_wr_en),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign busy   = (state_ff != ptwcnx_pkg::S_IDLE);
   assign accept = start && !busy;

   assign req_idx = WIDX_W'(req_word_index);
   assign top_idx = {1'b0, req_table_base[51:3]} + WIDX_W'(req_virt_addr[47:39]);
   assign pse     = mem_rdata[ptwcnx_pkg::PSE_BIT];

   // Masked table bases are at least 4 KiB aligned, so the index simply fills the low bits.
   always_comb begin
      case (level_ff)
         2'd0: next_idx = {1'b0, mem_rdata[51:12], va_ff[26:18]};
         2'd1: next_idx = pse ? {1'b0, mem_rdata[51:30], 18'b0, va_ff[17:9]}
                              : {1'b0, mem_rdata[51:12], va_ff[17:9]};
         default: next_idx = pse ? {1'b0, mem_rdata[51:21], 9'b0, va_ff[8:0]}
                                 : {1'b0, mem_rdata[51:12], va_ff[8:0]};
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      level_in       = level_ff;
      va_in          = va_ff;
      addr_in        = addr_ff;
      rsp_strobe_in  = 1'b0;
      status_in      = ptwcnx_pkg::ST_OK;
      read_data_in   = '0;
      entry_index_in = '0;
      before_in      = '0;
      after_in       = '0;
      mem_rd_en      = 1'b0;
      mem_wr_en      = 1'b0;
      mem_addr       = '0;
      mem_wdata      = req_write_data;

      unique case (state_ff)
         ptwcnx_pkg::S_IDLE: begin
            if (accept) begin
               unique case (ptwcnx_pkg::kind_type'(req_kind))
                  ptwcnx_pkg::KIND_WRITE: begin
                     rsp_strobe_in = 1'b1;
                     mem_addr      = req_idx[AW-1:0];
                     if (req_idx < MEM_LIMIT) begin
                        mem_wr_en = 1'b1;
                     end else begin
                        status_in = ptwcnx_pkg::ST_OUTSIDE;
                     end
                  end
                  ptwcnx_pkg::KIND_READ: begin
                     mem_addr = req_idx[AW-1:0];
                     if (req_idx < MEM_LIMIT) begin
                        mem_rd_en = 1'b1;
                        state_in  = ptwcnx_pkg::S_READ;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        status_in     = ptwcnx_pkg::ST_OUTSIDE;
                     end
                  end
                  ptwcnx_pkg::KIND_WALK: begin
                     mem_addr = top_idx[AW-1:0];
                     if (top_idx < MEM_LIMIT) begin
                        mem_rd_en = 1'b1;
                        level_in  = 2'd0;
                        va_in     = req_virt_addr[38:12];
                        addr_in   = top_idx[AW-1:0];
                        state_in  = ptwcnx_pkg::S_WALK;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        status_in     = ptwcnx_pkg::ST_OUTSIDE;
                     end
                  end
                  ptwcnx_pkg::KIND_NONE: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         ptwcnx_pkg::S_READ: begin
            rsp_strobe_in = 1'b1;
            read_data_in  = mem_rdata;
            state_in      = ptwcnx_pkg::S_IDLE;
         end

         ptwcnx_pkg::S_WALK: begin
            if (level_ff == 2'd3) begin
               // The final entry is written back in the cycle its value arrives.
               mem_wr_en      = 1'b1;
               mem_addr       = addr_ff;
               mem_wdata      = {1'b0, mem_rdata[62:0]};
               rsp_strobe_in  = 1'b1;
               entry_index_in = 16'(addr_ff);
               before_in      = mem_rdata;
               after_in       = {1'b0, mem_rdata[62:0]};
               state_in       = ptwcnx_pkg::S_IDLE;
            end else if (mem_rdata == 64'd0) begin
               rsp_strobe_in = 1'b1;
               state_in      = ptwcnx_pkg::S_IDLE;
               case (level_ff)
                  2'd0:    status_in = ptwcnx_pkg::ST_TOP_ZERO;
                  2'd1:    status_in = ptwcnx_pkg::ST_L3_ZERO;
                  default: status_in = ptwcnx_pkg::ST_L2_ZERO;
               endcase
            end else if (next_idx < MEM_LIMIT) begin
               mem_rd_en = 1'b1;
               mem_addr  = next_idx[AW-1:0];
               addr_in   = next_idx[AW-1:0];
               level_in  = level_ff + 2'd1;
            end else begin
               rsp_strobe_in = 1'b1;
               status_in     = ptwcnx_pkg::ST_OUTSIDE;
               state_in      = ptwcnx_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = ptwcnx_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ptwcnx_pkg::S_IDLE;
         level_ff      <= 2'd0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         level_ff      <= level_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff   <= va_in;
      addr_ff <= addr_in;
      if (rsp_strobe_in) begin
         status_ff      <= status_in;
         read_data_ff   <= read_data_in;
         entry_index_ff <= entry_index_in;
         before_ff      <= before_in;
         after_ff       <= after_in;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_read_data    = read_data_ff;
   assign rsp_entry_index  = entry_index_ff;
   assign rsp_entry_before = before_ff;
   assign rsp_entry_after  = after_ff;

endmodule

### hdl/ptwcnx_checker.sv
// Port-level checks for the page-table walk core, bound to the top level.
`timescale 1ns / 1ps
module ptwcnx_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [2:0]  rsp_status,
   input logic [63:0] rsp_read_data,
   input logic [15:0] rsp_entry_index,
   input logic [63:0] rsp_entry_before,
   input logic [63:0] rsp_entry_after
);

   // A result is shown only while the core is free to take the next item.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // Every accepted item either answers at once or keeps the core busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("accepted item neither answered nor in progress");

   // The modified entry differs from the original in the NX bit alone.
   a_nx_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_entry_after == {1'b0, rsp_entry_before[62:0]}))
      else $error("entry after differs from entry before beyond NX");

   // A failed item reports nothing but its status.
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ptwcnx_pkg::ST_OK)) |->
      (rsp_read_data == 64'd0 && rsp_entry_index == 16'd0 &&
       rsp_entry_before == 64'd0 && rsp_entry_after == 64'd0))
      else $error("failed item carries payload");

endmodule

bind page_table_walk_clear_nx_core ptwcnx_checker u_ptwcnx_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_status       (rsp_status),
   .rsp_read_data    (rsp_read_data),
   .rsp_entry_index  (rsp_entry_index),
   .rsp_entry_before (rsp_entry_before),
   .rsp_entry_after  (rsp_entry_after)
);

### sim/page_table_walk_clear_nx_core_checker.sv
// Result checker for the page-table walk core: mirrors the memory image and compares results.
`timescale 1ns / 1ps
module page_table_walk_clear_nx_core_checker #(
   parameter int unsigned MEM_WORDS = ptwcnx_pkg::MEM_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_word_index,
   input  logic [63:0] req_write_data,
   input  logic [51:0] req_table_base,
   input  logic [47:0] req_virt_addr,
   input  logic        rsp_strobe,
   input  logic [2:0]  rsp_status,
   input  logic [63:0] rsp_read_data,
   input  logic [15:0] rsp_entry_index,
   input  logic [63:0] rsp_entry_before,
   input  logic [63:0] rsp_entry_after,
   output int          errors,
   output int          pending
);

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] read_data;
      logic [15:0] entry_index;
      logic [63:0] entry_before;
      logic [63:0] entry_after;
   } outcome_type;

   logic [63:0] image [MEM_WORDS];
   outcome_type outcome_q [$];
   int unsigned rsp_seen;

   initial begin
      errors = 0;
      pending = 0;
      rsp_seen = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: result %0d: %s", $time, rsp_seen, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
   endtask

   // Word index of slot idx in a table whose base is given in words.
   function automatic logic [ptwcnx_pkg::WIDX_W-1:0] table_slot(
         input logic [48:0] table_words, input logic [8:0] idx);
      return table_words + idx;
   endfunction

   // Applies one accepted item to the mirrored image and returns the result it must give.
   task automatic apply_item(input logic [1:0] kind, input logic [15:0] idx,
                             input logic [63:0] data, input logic [51:0] base,
                             input logic [47:0] va, output outcome_type o);
      logic [ptwcnx_pkg::WIDX_W-1:0] w;
      logic [63:0] e;
      logic [48:0] tbl;
      bit done;
      o = '0;
      done = 1'b0;
      case (kind)
         ptwcnx_pkg::KIND_WRITE: begin
            if (idx >= MEM_WORDS) o.status = ptwcnx_pkg::ST_OUTSIDE;
            else image[idx] = data;
         end
         ptwcnx_pkg::KIND_READ: begin
            if (idx >= MEM_WORDS) o.status = ptwcnx_pkg::ST_OUTSIDE;
            else o.read_data = image[idx];
         end
         ptwcnx_pkg::KIND_WALK: begin
            w = table_slot(base[51:3], va[47:39]);
            for (int lv = 0; lv < 4 && !done; lv++) begin
               if (w >= MEM_WORDS) begin
                  o.status = ptwcnx_pkg::ST_OUTSIDE;
                  done = 1'b1;
               end else begin
                  e = image[w];
                  if (lv == 3) begin
                     o.entry_index = w[15:0];
                     o.entry_before = e;
                     e[ptwcnx_pkg::NX_BIT] = 1'b0;
                     o.entry_after = e;
                     image[w] = e;
                  end else if (e == '0) begin
                     o.status = (lv == 0) ? ptwcnx_pkg::ST_TOP_ZERO :
                                (lv == 1) ? ptwcnx_pkg::ST_L3_ZERO :
                                            ptwcnx_pkg::ST_L2_ZERO;
                     done = 1'b1;
                  end else begin
                     // A large-page entry still names the next table, on a coarser boundary.
                     if (lv == 1 && e[ptwcnx_pkg::PSE_BIT]) tbl = {e[51:30], 27'b0};
                     else if (lv == 2 && e[ptwcnx_pkg::PSE_BIT]) tbl = {e[51:21], 18'b0};
                     else tbl = {e[51:12], 9'b0};
                     w = table_slot(tbl, 9'(va >> (30 - 9 * lv)));
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      outcome_type want;
      outcome_type fresh;
      if (!reset) begin
         // A result and a new transfer can share an edge; the result is always older.
         if (rsp_strobe) begin
            if (outcome_q.size() == 0) begin
               report_mismatch("result strobe with no item outstanding");
            end else begin
               want = outcome_q.pop_front();
               check_field("status", 64'(rsp_status), 64'(want.status));
               check_field("read_data", rsp_read_data, want.read_data);
               check_field("entry_index", 64'(rsp_entry_index), 64'(want.entry_index));
               check_field("entry_before", rsp_entry_before, want.entry_before);
               check_field("entry_after", rsp_entry_after, want.entry_after);
            end
            rsp_seen++;
         end
         if (start && !busy) begin
            apply_item(req_kind, req_word_index, req_write_data, req_table_base,
                       req_virt_addr, fresh);
            outcome_q.push_back(fresh);
         end
         pending = outcome_q.size();
      end
   end

endmodule

### sim/page_table_walk_clear_nx_core_tb.sv
// Testbench top for the page-table walk core: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps
module page_table_walk_clear_nx_core_tb;

   localparam int unsigned MEM_WORDS = ptwcnx_pkg::MEM_WORDS_DEF;
   localparam int unsigned RANDOM_ITEMS = 1350;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef enum logic [1:0] {
      LINK_TABLE,
      LINK_HUGE,
      LINK_ZERO,
      LINK_AWAY
   } link_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_kind;
   logic [15:0] req_word_index;
   logic [63:0] req_write_data;
   logic [51:0] req_table_base;
   logic [47:0] req_virt_addr;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_read_data;
   logic [15:0] rsp_entry_index;
   logic [63:0] rsp_entry_before;
   logic [63:0] rsp_entry_after;
   int          errors;
   int          pending;

   int unsigned idle_pct;
   int unsigned sent;
   int unsigned cycles = 0;
   bit          written [MEM_WORDS];
   logic [15:0] written_list [$];
   logic [51:0] last_base;
   logic [47:0] last_va;
   bit          walk_ready;

   page_table_walk_clear_nx_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_word_index(req_word_index),
      .req_write_data(req_write_data), .req_table_base(req_table_base),
      .req_virt_addr(req_virt_addr), .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status), .rsp_read_data(rsp_read_data),
      .rsp_entry_index(rsp_entry_index), .rsp_entry_before(rsp_entry_before),
      .rsp_entry_after(rsp_entry_after)
   );

   page_table_walk_clear_nx_core_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_word_index(req_word_index),
      .req_write_data(req_write_data), .req_table_base(req_table_base),
      .req_virt_addr(req_virt_addr), .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status), .rsp_read_data(rsp_read_data),
      .rsp_entry_index(rsp_entry_index), .rsp_entry_before(rsp_entry_before),
      .rsp_entry_after(rsp_entry_after), .errors(errors), .pending(pending)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("page_table_walk_clear_nx_core_tb: done, errors");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic link_type pick_link(input int lv);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 7) return LINK_ZERO;
      if (r < 13) return LINK_AWAY;
      if (r < 22 && lv > 0) return LINK_HUGE;
      return LINK_TABLE;
   endfunction

   // Holds one item on the request ports until its transfer, then idles at random.
   task automatic issue(input ptwcnx_pkg::kind_type k, input logic [15:0] idx,
                        input logic [63:0] data, input logic [51:0] base,
                        input logic [47:0] va);
      start <= 1'b1;
      req_kind <= k;
      req_word_index <= idx;
      req_write_data <= data;
      req_table_base <= base;
      req_virt_addr <= va;
      do @(posedge clock); while (busy);
      sent++;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic store_word(input logic [15:0] idx, input logic [63:0] data);
      issue(ptwcnx_pkg::KIND_WRITE, idx, data, 52'(rand64()), 48'(rand64()));
      if (!written[idx]) begin
         written[idx] = 1'b1;
         written_list.push_back(idx);
      end
      walk_ready = 1'b0;
   endtask

   // Writes every entry that the walk will read, then starts the walk. A slot that the
   // path already wrote is reused as it stands, so no entry is read before it is written.
   task automatic walk_path(input logic [51:0] base, input logic [47:0] va,
                            input link_type l0, input link_type l1, input link_type l2,
                            input logic [63:0] leaf);
      logic [ptwcnx_pkg::WIDX_W-1:0] w;
      logic [63:0] e;
      logic [48:0] tbl;
      logic [15:0] path_w [4];
      logic [63:0] path_e [4];
      link_type links [3];
      int n;
      bit hit;
      bit done;
      links[0] = l0;
      links[1] = l1;
      links[2] = l2;
      n = 0;
      done = 1'b0;
      w = base[51:3] + va[47:39];
      for (int lv = 0; lv < 4 && !done; lv++) begin
         if (w >= MEM_WORDS) begin
            done = 1'b1;
         end else begin
            hit = 1'b0;
            for (int j = 0; j < n; j++) begin
               if (path_w[j] == w[15:0]) begin
                  hit = 1'b1;
                  e = path_e[j];
               end
            end
            if (!hit) begin
               if (lv == 3) begin
                  e = leaf;
               end else begin
                  case (links[lv])
                     LINK_ZERO: e = '0;
                     LINK_HUGE: begin
                        e = rand64();
                        if (lv == 1) e[51:30] = '0;
                        else e[51:21] = '0;
                        e[ptwcnx_pkg::PSE_BIT] = 1'b1;
                     end
                     LINK_AWAY: begin
                        e = rand64();
                        if (lv > 0 && $urandom_range(1) == 1) begin
                           e[ptwcnx_pkg::PSE_BIT] = 1'b1;
                           e[30 + $urandom_range(21)] = 1'b1;
                        end else begin
                           if (lv > 0) e[ptwcnx_pkg::PSE_BIT] = 1'b0;
                           e[19 + $urandom_range(32)] = 1'b1;
                        end
                     end
                     default: begin
                        e = {12'($urandom), 33'b0, 7'($urandom_range(127)), 12'($urandom)};
                        e[0] = 1'b1;
                        if (lv > 0) e[ptwcnx_pkg::PSE_BIT] = 1'b0;
                     end
                  endcase
               end
               store_word(w[15:0], e);
               path_w[n] = w[15:0];
               path_e[n] = e;
               n++;
            end
            if (lv == 3 || e == '0) begin
               done = 1'b1;
            end else begin
               if (lv == 1 && e[ptwcnx_pkg::PSE_BIT]) tbl = {e[51:30], 27'b0};
               else if (lv == 2 && e[ptwcnx_pkg::PSE_BIT]) tbl = {e[51:21], 18'b0};
               else tbl = {e[51:12], 9'b0};
               w = tbl + 9'(va >> (30 - 9 * lv));
            end
         end
      end
      issue(ptwcnx_pkg::KIND_WALK, 16'($urandom), rand64(), base, va);
      last_base = base;
      last_va = va;
      walk_ready = 1'b1;
   endtask

   initial begin : stimulus
      int unsigned first_random;
      int unsigned progress;
      int unsigned r;
      logic [51:0] base;
      logic [63:0] leaf;
      reset = 1'b1;
      start = 1'b0;
      req_kind = ptwcnx_pkg::KIND_NONE;
      req_word_index = '0;
      req_write_data = '0;
      req_table_base = '0;
      req_virt_addr = '0;
      idle_pct = 8;
      sent = 0;
      walk_ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Extremes of the plain word traffic and the unused kind.
      store_word(16'h0000, 64'h0);
      store_word(16'hFFFF, {64{1'b1}});
      issue(ptwcnx_pkg::KIND_READ, 16'hFFFF, rand64(), 52'(rand64()), 48'(rand64()));
      issue(ptwcnx_pkg::KIND_NONE, 16'($urandom), rand64(), 52'(rand64()), 48'(rand64()));
      // Top-level table far outside the image.
      issue(ptwcnx_pkg::KIND_WALK, 16'($urandom), rand64(), {52{1'b1}}, {48{1'b1}});
      // Full walk from an unaligned base, with NX set, then the same walk once NX is gone.
      walk_path(52'h0_0000_0000_1005, 48'(rand64()), LINK_TABLE, LINK_TABLE, LINK_TABLE,
                {64{1'b1}});
      issue(ptwcnx_pkg::KIND_WALK, 16'($urandom), rand64(), last_base, last_va);
      // Walks that stop on a zero entry at each upper level.
      walk_path(52'h0_0000_0000_2000, 48'(rand64()), LINK_ZERO, LINK_TABLE, LINK_TABLE,
                rand64());
      walk_path(52'h0_0000_0000_3000, 48'(rand64()), LINK_TABLE, LINK_ZERO, LINK_TABLE,
                rand64());
      walk_path(52'h0_0000_0000_4000, 48'(rand64()), LINK_TABLE, LINK_TABLE, LINK_ZERO,
                rand64());
      // Descent through both large-page sizes onto a zero final entry.
      walk_path(52'h0_0000_0000_5000, 48'(rand64()), LINK_TABLE, LINK_HUGE, LINK_HUGE, '0);

      first_random = sent;
      while (sent - first_random < RANDOM_ITEMS) begin
         progress = sent - first_random;
         idle_pct = (progress < RANDOM_ITEMS / 3) ? 8 :
                    (progress < 2 * RANDOM_ITEMS / 3) ? 67 : 0;
         r = $urandom_range(99);
         if (r < 55) begin
            if ($urandom_range(99) < 85)
               base = {33'b0, 7'($urandom_range(127)), 12'($urandom)};
            else
               base = 52'(rand64());
            leaf = rand64();
            if ($urandom_range(99) < 10) leaf = '0;
            else if ($urandom_range(99) < 40) leaf[ptwcnx_pkg::NX_BIT] = 1'b1;
            walk_path(base, 48'(rand64()), pick_link(0), pick_link(1), pick_link(2), leaf);
         end else if (r < 65 && walk_ready) begin
            issue(ptwcnx_pkg::KIND_WALK, 16'($urandom), rand64(), last_base, last_va);
         end else if (r < 80) begin
            store_word(16'($urandom), rand64());
         end else if (r < 95) begin
            issue(ptwcnx_pkg::KIND_READ,
                  written_list[$urandom_range(written_list.size() - 1)], rand64(),
                  52'(rand64()), 48'(rand64()));
         end else begin
            issue(ptwcnx_pkg::KIND_NONE, 16'($urandom), rand64(), 52'(rand64()),
                  48'(rand64()));
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("page_table_walk_clear_nx_core_tb: done, clean");
      else
         $display("page_table_walk_clear_nx_core_tb: done, errors");
      $finish;
   end

endmodule
